@@ sv/spm_pkg.sv @@
// Shared types, constants and helpers of the sample playback mixer.
package spm_pkg;

   localparam int SAMPLE_DEPTH = 16384;
   localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
   localparam int LEN_W = 15;
   localparam int POS_W = 31;
   localparam int ATTEN_W = 5;
   localparam int AUDIO_W = 16;
   localparam int RATE_W = 16;
   localparam logic [RATE_W-1:0] RATE_RESET = 16'd41610;
   localparam logic [ATTEN_W-1:0] MAX_ATTEN = 5'd16;
   localparam logic [LEN_W-1:0] MAX_LENGTH = LEN_W'(SAMPLE_DEPTH);

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_PAN   = 3'd3,
      OP_TICK  = 3'd4
   } op_type;

   // One tick on its way from the memory read to the output register.
   typedef struct packed {
      logic signed [AUDIO_W-1:0] music;
      logic [ATTEN_W-1:0]        left_gain;
      logic [ATTEN_W-1:0]        right_gain;
      logic                      positioned;
      logic                      active;
      logic                      playing;
   } tick_info_type;

   // Wrap a wide index into the sample memory.
   function automatic logic [ADDR_W-1:0] mem_index(input logic [31:0] value);
      mem_index = value[ADDR_W-1:0];
   endfunction

endpackage

@@ sv/spm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module spm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/spm_mix.sv @@
// One side of the mixer: center and scale a sample byte, add music, saturate; pass music through when inactive.
module spm_mix (
   input  logic [7:0]                          sample_byte,
   input  logic [spm_pkg::ATTEN_W-1:0]         gain,
   input  logic                                positioned,
   input  logic                                active,
   input  logic signed [spm_pkg::AUDIO_W-1:0]  music,
   output logic signed [spm_pkg::AUDIO_W-1:0]  mixed
);
   import spm_pkg::*;

   logic signed [8:0]  centered;
   logic signed [14:0] product;
   logic signed [17:0] scaled;
   logic signed [17:0] sum;

   always_comb begin
      centered = $signed({1'b0, sample_byte}) - 9'sd128;
      product = 15'(centered) * 15'($signed({1'b0, gain}));
      // positioned: centered * 256 * gain / 32; otherwise centered * 256 / 4
      if (positioned) begin
         scaled = {product, 3'b000};
      end else begin
         scaled = {{3{centered[8]}}, centered, 6'b000000};
      end
      sum = scaled + 18'(music);
      if (!active) begin
         mixed = music;
      end else if (sum > 18'sd32767) begin
         mixed = 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         mixed = 16'sh8000;
      end else begin
         mixed = sum[AUDIO_W-1:0];
      end
   end

endmodule

@@ sv/sample_playback_mixer_unit.sv @@
// Top level of the sample playback mixer: control state, memory read and output.
//
// Usage: items arrive on the req_ stream; req_tuser carries the operation
// (write byte, start, stop, set panning, tick) and req_tdata the operands.
// Only a tick yields a beat on the rsp_ stream: a stereo pair and the playing
// flag. The position increment lives in a register written through the csr_
// channel, which is always ready; write it only while the block is idle.
// Pipeline: a tick's sample-memory read registers as the tick is accepted; the
// mix of that byte lands in the output register once the output is free.
// Throughput: one item per cycle while the output is not stalled, set by the
// single read port of the sample memory, which one tick uses per cycle.
// A byte written by an accepted item is visible to any tick accepted later.
// Reset: synchronous, active high; the sound is silent, panning is cleared,
// the increment returns to 41610 and the pipeline empties. The sample memory
// is not cleared and must be loaded before a sound that reads it starts.
// Stall: while the result waits in the output register and a tick waits behind
// it, req_tready drops; nothing is lost or repeated.
module sample_playback_mixer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // config: rate_step
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spm_pkg::RATE_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tuser: operation
   input  logic [2:0]                        req_tuser,
   // tdata: address, sample_byte, sound_length, left_atten, right_atten,
   //        positioned, music_sample
   input  logic [spm_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: left_out, right_out, playing, zero fill
   output logic [spm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import spm_pkg::*;

   logic [13:0]              req_address;
   logic [7:0]               req_byte;
   logic [LEN_W-1:0]         req_length;
   logic [ATTEN_W-1:0]       req_left_atten;
   logic [ATTEN_W-1:0]       req_right_atten;
   logic                     req_positioned;
   logic signed [AUDIO_W-1:0] req_music;

   assign req_address     = req_tdata[13:0];
   assign req_byte        = req_tdata[21:14];
   assign req_length      = req_tdata[36:22];
   assign req_left_atten  = req_tdata[41:37];
   assign req_right_atten = req_tdata[46:42];
   assign req_positioned  = req_tdata[47];
   assign req_music       = req_tdata[63:48];

   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic               active_ff, active_in;
   logic [ATTEN_W-1:0] left_level_ff, left_level_in;
   logic [ATTEN_W-1:0] right_level_ff, right_level_in;
   logic               mode_ff, mode_in;

   tick_info_type      s1_ff, s1_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               req_accept;
   logic               tick_accept;
   logic               mem_wr_en;
   logic [7:0]         mem_rd_data;
   logic [POS_W-1:0]   next_position;
   logic               sound_ends;
   logic signed [AUDIO_W-1:0] left_mixed, right_mixed;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || out_free;
   assign req_accept  = req_tvalid && req_tready;
   assign tick_accept = req_accept && (req_tuser == OP_TICK);
   assign mem_wr_en   = req_accept && (req_tuser == OP_WRITE);
   assign csr_ready   = 1'b1;

   assign next_position = position_ff + POS_W'(rate_ff);
   assign sound_ends    = next_position[POS_W-1:16] >= length_ff;

   spm_ram #(
      .WIDTH (8),
      .DEPTH (SAMPLE_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_index(32'(req_address))),
      .wr_data (req_byte),
      .rd_en   (tick_accept),
      .rd_addr (mem_index(32'(position_ff[POS_W-1:16]))),
      .rd_data (mem_rd_data)
   );

   // Control state updates at accept time; the tick's view travels in s1.
   always_comb begin
      rate_in        = rate_ff;
      position_in    = position_ff;
      length_in      = length_ff;
      active_in      = active_ff;
      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      mode_in        = mode_ff;
      if (csr_valid && csr_ready) begin
         rate_in = csr_wdata;
      end
      if (req_accept) begin
         unique case (req_tuser)
            OP_START: begin
               length_in   = (req_length > MAX_LENGTH) ? MAX_LENGTH : req_length;
               position_in = '0;
               active_in   = 1'b1;
            end
            OP_STOP: begin
               active_in = 1'b0;
            end
            OP_PAN: begin
               left_level_in  = (req_left_atten > MAX_ATTEN) ? MAX_ATTEN
                                                             : req_left_atten;
               right_level_in = (req_right_atten > MAX_ATTEN) ? MAX_ATTEN
                                                              : req_right_atten;
               mode_in        = req_positioned;
            end
            OP_TICK: begin
               if (active_ff) begin
                  position_in = next_position;
                  if (sound_ends) begin
                     active_in = 1'b0;
                     mode_in   = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_in.music      = req_music;
      s1_in.left_gain  = MAX_ATTEN - left_level_ff;
      s1_in.right_gain = MAX_ATTEN - right_level_ff;
      s1_in.positioned = mode_ff;
      s1_in.active     = active_ff;
      s1_in.playing    = active_ff && !sound_ends;
   end

   spm_mix u_mix_left (
      .sample_byte (mem_rd_data),
      .gain        (s1_ff.left_gain),
      .positioned  (s1_ff.positioned),
      .active      (s1_ff.active),
      .music       (s1_ff.music),
      .mixed       (left_mixed)
   );

   spm_mix u_mix_right (
      .sample_byte (mem_rd_data),
      .gain        (s1_ff.right_gain),
      .positioned  (s1_ff.positioned),
      .active      (s1_ff.active),
      .music       (s1_ff.music),
      .mixed       (right_mixed)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = {7'b0, s1_ff.playing, right_mixed, left_mixed};
         s1_valid_in  = 1'b0;
      end
      if (tick_accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff        <= RATE_RESET;
         position_ff    <= '0;
         length_ff      <= '0;
         active_ff      <= 1'b0;
         left_level_ff  <= '0;
         right_level_ff <= '0;
         mode_ff        <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rate_ff        <= rate_in;
         position_ff    <= position_in;
         length_ff      <= length_in;
         active_ff      <= active_in;
         left_level_ff  <= left_level_in;
         right_level_ff <= right_level_in;
         mode_ff        <= mode_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Hold tick info while stalled so it stays paired with the held read data.
   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_ff <= s1_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_tick_over_full: assert property (@(posedge clock) disable iff (reset)
      !(tick_accept && s1_valid_ff && !out_free))
      else $error("tick accepted while the mix stage is stalled");

   a_stall_keeps_tick: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("stalled tick dropped from the mix stage");

   a_silent_passthrough: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free && !s1_ff.active) |=>
      (rsp_tdata[15:0] == $past(s1_ff.music)) && (rsp_tdata[31:16] == $past(s1_ff.music)))
      else $error("silent tick did not pass music through");

   a_playing_needs_active: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (!s1_ff.playing || s1_ff.active))
      else $error("playing flagged for a tick that had no sound");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the sample playback mixer: directed table, then random sessions.
`timescale 1ns / 100ps

module tb_top;
   import spm_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS = 110;
   localparam int NUM_PHASES = 5;

   typedef struct packed {
      logic [2:0]                op;
      logic [ADDR_W-1:0]         addr;
      logic [7:0]                sbyte;
      logic [LEN_W-1:0]          sound_len;
      logic [ATTEN_W-1:0]        atten_l;
      logic [ATTEN_W-1:0]        atten_r;
      logic                      positioned;
      logic signed [AUDIO_W-1:0] music;
   } mix_req_type;

   typedef struct packed {
      logic signed [AUDIO_W-1:0] left;
      logic signed [AUDIO_W-1:0] right;
      logic                      playing;
   } mix_out_type;

   typedef struct {
      mix_req_type req;
      bit          chk;
      mix_out_type want;
   } mix_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [RATE_W-1:0]     csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [2:0]            req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Mixer state as predicted from the accepted items
   logic [7:0]         voice_mem [SAMPLE_DEPTH];
   bit                 mem_written [SAMPLE_DEPTH];
   logic [POS_W-1:0]   voice_pos = '0;
   logic [LEN_W-1:0]   voice_len = '0;
   logic               voice_on = 1'b0;
   logic [ATTEN_W-1:0] gain_l = '0;
   logic [ATTEN_W-1:0] gain_r = '0;
   logic               pan_mode = 1'b0;
   logic [RATE_W-1:0]  step_size = RATE_RESET;

   mix_out_type expected_pairs [$];
   int errors = 0;
   int items_sent = 0;
   int pairs_checked = 0;
   int sounds_started = 0;
   int sounds_ended = 0;
   int rates_used = 1;
   int idle_pct = 0;
   int stall_pct = 0;

   // op, addr, byte, length, atten_l, atten_r, positioned, music; check; left, right, playing
   mix_row_type dir_rows [26] = '{
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0, -32768}, 1, '{-32768, -32768, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0,  32767}, 1, '{ 32767,  32767, 0}},
      '{'{OP_SPARE_LO, 0,  0,   0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_SPARE_HI, 0,  0,   0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_WRITE, 0,     255, 0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_WRITE, 1,     0,   0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_WRITE, 16383, 128, 0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_PAN,   0,     0,   0,     0,  16, 1,      0}, 0, '{0, 0, 0}},
      '{'{OP_START, 0,     0,   0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0,  32767}, 1, '{ 32767,  32767, 0}},
      '{'{OP_START, 0,     0,   2,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0, -32768}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0, -32768}, 1, '{-32768, -32768, 1}},
      '{'{OP_PAN,   0,     0,   0,     31, 20, 1,      0}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0,   1234}, 0, '{0, 0, 0}},
      '{'{OP_START, 0,     0,   32767, 0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_PAN,   0,     0,   0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_START, 0,     0,   3,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_STOP,  0,     0,   0,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0,     -1}, 1, '{-1, -1, 0}},
      '{'{OP_PAN,   0,     0,   0,     8,  0,  1,      0}, 0, '{0, 0, 0}},
      '{'{OP_START, 0,     0,   1,     0,  0,  0,      0}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0, -32768}, 0, '{0, 0, 0}},
      '{'{OP_TICK,  0,     0,   0,     0,  0,  0,  32767}, 0, '{0, 0, 0}}
   };

   sample_playback_mixer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic signed [AUDIO_W-1:0] sat16(input int v);
      if (v > 32767)
         return 16'sh7FFF;
      if (v < -32768)
         return 16'sh8000;
      return AUDIO_W'(v);
   endfunction

   // Apply one item to the predicted state; return 1 when it yields a stereo pair.
   function automatic bit mix_advance(input mix_req_type it, output mix_out_type res);
      int centered;
      int side_l;
      int side_r;
      logic [ADDR_W-1:0] idx;
      res = '0;
      case (it.op)
         OP_WRITE: begin
            voice_mem[it.addr] = it.sbyte;
            mem_written[it.addr] = 1'b1;
         end
         OP_START: begin
            voice_len = (it.sound_len > MAX_LENGTH) ? MAX_LENGTH : it.sound_len;
            voice_pos = '0;
            voice_on = 1'b1;
            sounds_started++;
         end
         OP_STOP: voice_on = 1'b0;
         OP_PAN: begin
            gain_l = (it.atten_l > MAX_ATTEN) ? MAX_ATTEN : it.atten_l;
            gain_r = (it.atten_r > MAX_ATTEN) ? MAX_ATTEN : it.atten_r;
            pan_mode = it.positioned;
         end
         OP_TICK: begin
            if (voice_on) begin
               idx = voice_pos[ADDR_W+15:16];
               centered = int'(voice_mem[idx]) - 128;
               if (pan_mode) begin
                  side_l = centered * 8 * (int'(MAX_ATTEN) - int'(gain_l));
                  side_r = centered * 8 * (int'(MAX_ATTEN) - int'(gain_r));
               end else begin
                  side_l = centered * 64;
                  side_r = side_l;
               end
               res.left = sat16(side_l + int'(it.music));
               res.right = sat16(side_r + int'(it.music));
               voice_pos = voice_pos + POS_W'(step_size);
               if (voice_pos[POS_W-1:16] >= voice_len) begin
                  voice_on = 1'b0;
                  pan_mode = 1'b0;
                  sounds_ended++;
               end
            end else begin
               res.left = it.music;
               res.right = it.music;
            end
            res.playing = voice_on;
         end
         default: ;
      endcase
      return it.op == OP_TICK;
   endfunction

   function automatic mix_req_type rand_item(input logic [2:0] op);
      mix_req_type it;
      it.op = op;
      it.addr = ADDR_W'($urandom_range(SAMPLE_DEPTH - 1));
      case ($urandom_range(7))
         0: it.sbyte = 8'd0;
         1: it.sbyte = 8'hFF;
         default: it.sbyte = 8'($urandom_range(255));
      endcase
      it.sound_len = LEN_W'($urandom_range(32767));
      it.atten_l = ATTEN_W'($urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(16));
      it.atten_r = ATTEN_W'($urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(16));
      it.positioned = 1'($urandom_range(1));
      case ($urandom_range(7))
         0: it.music = 16'sh7FFF;
         1: it.music = 16'sh8000;
         default: it.music = AUDIO_W'($urandom_range(65535));
      endcase
      return it;
   endfunction

   task automatic send_item(input mix_req_type it, input bit typed, input mix_out_type want);
      mix_out_type res;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= {it.music, it.positioned, it.atten_r, it.atten_l, it.sound_len,
                    it.sbyte, it.addr};
      do @(posedge clock); while (!req_tready);
      if (mix_advance(it, res))
         expected_pairs.push_back(typed ? want : res);
      if (it.op <= OP_TICK)
         items_sent++;
   endtask

   // Load the byte the next tick will read if it was never written, then tick.
   task automatic play_tick();
      mix_req_type it;
      logic [ADDR_W-1:0] idx;
      idx = voice_pos[ADDR_W+15:16];
      if (voice_on && !mem_written[idx]) begin
         it = rand_item(OP_WRITE);
         it.addr = idx;
         send_item(it, 1'b0, '0);
      end
      send_item(rand_item(OP_TICK), 1'b0, '0);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_pairs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [RATE_W-1:0] rate);
      csr_valid <= 1'b1;
      csr_wdata <= rate;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      step_size = rate;
      rates_used++;
   endtask

   // One sound: optional panning, start, a run of ticks with some noise, maybe a stop.
   task automatic play_session();
      mix_req_type it;
      int n_ticks;
      if ($urandom_range(2) == 0)
         send_item(rand_item(OP_PAN), 1'b0, '0);
      it = rand_item(OP_START);
      if ($urandom_range(9) != 0)
         it.sound_len = LEN_W'($urandom_range(40));
      send_item(it, 1'b0, '0);
      n_ticks = $urandom_range(30, 1);
      repeat (n_ticks) begin
         if ($urandom_range(9) == 0) begin
            it = rand_item(3'($urandom_range(7)));
            if (it.op == OP_TICK)
               play_tick();
            else
               send_item(it, 1'b0, '0);
         end
         play_tick();
      end
      if ($urandom_range(4) == 0)
         send_item(rand_item(OP_STOP), 1'b0, '0);
      // hold off now and then until the mixer has emptied
      if ($urandom_range(39) == 0)
         drain_results();
   endtask

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : check_pairs
      mix_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_pairs.pop_front();
            pairs_checked++;
            if (rsp_tdata[15:0] !== want.left) begin
               $display("%0t: left_out expected %0d got %0d", $time, want.left,
                        $signed(rsp_tdata[15:0]));
               errors++;
            end
            if (rsp_tdata[31:16] !== want.right) begin
               $display("%0t: right_out expected %0d got %0d", $time, want.right,
                        $signed(rsp_tdata[31:16]));
               errors++;
            end
            if (rsp_tdata[32] !== want.playing) begin
               $display("%0t: playing expected %0b got %0b", $time, want.playing,
                        rsp_tdata[32]);
               errors++;
            end
         end
      end
   end

   initial begin
      int phase_idle [NUM_PHASES];
      int phase_stall [NUM_PHASES];
      int goal;
      logic [RATE_W-1:0] rate;
      mix_req_type it;
      phase_idle = '{87, 0, 22, 0, 0};
      phase_stall = '{0, 87, 22, 0, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_item(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].want);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal)
         play_session();
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         if (p == 1)
            rate = 16'd1;
         else if (p == 0 || p == NUM_PHASES - 1)
            rate = 16'hFFFF;
         else
            rate = RATE_W'($urandom_range(65535, 1));
         write_rate(rate);
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         if (p == NUM_PHASES - 1) begin
            // start a length beyond the memory, play a few ticks, then stop it
            it = rand_item(OP_START);
            it.sound_len = LEN_W'(32767);
            send_item(it, 1'b0, '0);
            repeat (8)
               play_tick();
            send_item(rand_item(OP_STOP), 1'b0, '0);
         end
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal)
            play_session();
      end
      drain_results();
      $display("Run covered %0d items and %0d checked stereo pairs under %0d rate settings.",
               items_sent, pairs_checked, rates_used);
      $display("Sounds started: %0d, sounds played to their end: %0d.",
               sounds_started, sounds_ended);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
